@@ sv/gni_pkg.sv @@
// gni_pkg: shared types and constants for the grid neighbor index unit.
// No dependencies.
package gni_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int DIM_W     = 11;
    localparam int ID_W      = 30;
    localparam int NID_W     = 31;
    localparam int DIR_W     = 3;
    localparam int QUO_W     = 30;
    localparam int N_CELLS   = 30;   // one quotient bit per cell

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic REQ_ENUM = 1'b0;
    localparam logic REQ_FACE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

    // request item
    typedef struct packed {
        logic             req_type;
        logic [ID_W-1:0]  cell_id;
        logic [DIR_W-1:0] direction;
    } t_req;

    // result item
    typedef struct packed {
        logic [NID_W-1:0] neighbor_id;
        logic             at_border;
        logic             bad_index;
        logic             is_last;
    } t_res;

    typedef struct packed {
        logic             req_type;
        logic [DIR_W-1:0] direction;
        logic             bad;
        logic [NID_W-1:0] total;
        logic [20:0]      plane;
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
    } t_ctx;

    // state of one division cell: partial remainder and quotient bits so far
    typedef struct packed {
        logic             vld;
        t_ctx             ctx;
        logic [ID_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

@@ sv/gni_if.sv @@
// gni_if: valid/ready channels for lookup request items and result items.
// Depends on gni_pkg.
interface gni_req_if import gni_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gni_res_if import gni_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/gni_div_cell.sv @@
// gni_div_cell: one restoring-division cell, resolves one quotient bit.
// Depends on gni_pkg.
module gni_div_cell import gni_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  [4:0]  i_bit,
    input  logic  [20:0] i_divisor,
    input  t_div  i_d,
    output t_div  o_d
);
    t_div r_d, n_d;
    logic [51:0] w_trial;

    always_comb begin
        n_d = i_d;
        w_trial = 52'(i_divisor) << i_bit;
        if (52'(i_d.rem) >= w_trial) begin
            n_d.rem = i_d.rem - ID_W'(w_trial);
            n_d.quo[i_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= n_d.vld;
        end
        if (i_en) begin
            r_d.ctx <= n_d.ctx;
            r_d.rem <= n_d.rem;
            r_d.quo <= n_d.quo;
        end
    end

    assign o_d = r_d;
endmodule

@@ sv/gni_div_chain.sv @@
// gni_div_chain: row of division cells, one quotient bit per cell, MSB first.
// Depends on gni_pkg and gni_div_cell.
module gni_div_chain import gni_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_by_plane,
    input  t_div  i_d,
    output t_div  o_d
);
    t_div w_d [N_CELLS+1];
    assign w_d[0] = i_d;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        logic [20:0] w_div;
        assign w_div = i_by_plane ? w_d[g].ctx.plane : 21'(w_d[g].ctx.nx);
        gni_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (i_en),
            .i_bit     (5'(N_CELLS-1-g)),
            .i_divisor (w_div),
            .i_d       (w_d[g]),
            .o_d       (w_d[g+1])
        );
    end

    assign o_d = w_d[N_CELLS];
endmodule

@@ sv/grid_neighbor_index_unit.sv @@
// Grid neighbor index unit: splits a linear cell index of an x-fastest grid
// into x, y, z and emits neighbor indices. Depends on gni_pkg, gni_if, gni_div_chain.
//
// An item passes two rows of 30 division cells (z by the plane size, then y/x by
// size_x). The emitter then loads a face or error item and offers its one result,
// or loads an enumerate item and walks its 27 offsets, one per cycle while the
// output is not stalled, plus a flush step when the +1,+1,+1 neighbor exists,
// giving 1 to 26 result items at most one per cycle. The cell rows advance only
// while the emitter is idle, so the input takes no new item while the emitter is
// busy. The input also holds off after reset and after each configuration write
// while the grid sizes settle; configure only while no item is in flight.
module grid_neighbor_index_unit import gni_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    gni_req_if.sink          i_req,
    gni_res_if.source        o_res
);
    logic [DIM_W-1:0] r_size_x, r_size_y, r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= DIM_W'(1);
            r_size_y <= DIM_W'(1);
            r_size_z <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective dims and products, registered off the config registers
    logic [DIM_W-1:0] r_nx, r_ny, r_nz;
    logic [20:0]      r_plane;
    logic [NID_W-1:0] r_total;
    always_ff @(posedge i_clk) begin
        r_nx    <= eff_dim(r_size_x);
        r_ny    <= eff_dim(r_size_y);
        r_nz    <= eff_dim(r_size_z);
        r_plane <= r_nx * r_ny;
        r_total <= NID_W'(r_plane * r_nz);
    end

    // input held off until the products above have caught up with a write
    logic [1:0] r_cfg_hold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= 2'd3;
        end else if (i_cfg_we) begin
            r_cfg_hold <= 2'd3;
        end else if (r_cfg_hold != 2'd0) begin
            r_cfg_hold <= r_cfg_hold - 2'd1;
        end
    end

    // pipeline advance: emitter ready to load a new item
    logic w_adv;

    t_div w_in, w_s1, w_mid, w_s2;
    always_comb begin
        w_in.vld = i_req.valid && i_req.ready;
        w_in.ctx.req_type  = i_req.data.req_type;
        w_in.ctx.direction = i_req.data.direction;
        w_in.ctx.bad       = NID_W'(i_req.data.cell_id) >= r_total;
        w_in.ctx.total     = r_total;
        w_in.ctx.plane     = r_plane;
        w_in.ctx.nx        = r_nx;
        w_in.ctx.ny        = r_ny;
        w_in.ctx.nz        = r_nz;
        w_in.rem = i_req.data.cell_id;
        w_in.quo = '0;
    end

    gni_div_chain u_zdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_by_plane(1'b1),
        .i_d(w_in), .o_d(w_s1)
    );

    // z in r_zq: carry z by parking it in a side pipe
    logic [DIM_W-1:0] r_zq [N_CELLS];
    always_comb begin
        w_mid = w_s1;
        w_mid.quo = '0;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zq[0] <= DIM_W'(w_s1.quo);
            for (int k = 1; k < N_CELLS; k++) r_zq[k] <= r_zq[k-1];
        end
    end

    gni_div_chain u_ydiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_by_plane(1'b0),
        .i_d(w_mid), .o_d(w_s2)
    );

    // emitter: walks the 27 offsets, one per cycle while the output slot is free; 0..2 stands for -1..+1
    logic             r_busy;
    t_ctx             r_ctx;
    logic [DIM_W-1:0] r_px, r_py, r_pz;
    logic [1:0]       r_ox, r_oy, r_oz;
    logic             r_fin;

    // output register
    logic             r_ovld;
    logic [NID_W-1:0] r_oid;
    logic             r_obd, r_obad, r_olast;

    logic w_oslot;
    assign w_oslot     = !r_ovld || o_res.ready;
    assign w_adv       = !r_busy;
    assign i_req.ready = w_adv && (r_cfg_hold == 2'd0);

    logic        w_inb, w_lastk, w_center;
    logic [DIM_W:0] w_x, w_y, w_z;
    logic [NID_W-1:0] w_lin;
    logic        w_ok;
    logic [DIM_W:0] w_dx, w_dy, w_dz;
    logic [NID_W-1:0] w_dlin;

    always_comb begin
        w_x  = {1'b0, r_px} + (DIM_W+1)'(r_ox) - (DIM_W+1)'(1);
        w_y  = {1'b0, r_py} + (DIM_W+1)'(r_oy) - (DIM_W+1)'(1);
        w_z  = {1'b0, r_pz} + (DIM_W+1)'(r_oz) - (DIM_W+1)'(1);
        w_center = (r_ox == 2'd1) && (r_oy == 2'd1) && (r_oz == 2'd1);
        w_inb = !w_center && !w_x[DIM_W] && !w_y[DIM_W] && !w_z[DIM_W]
                && (w_x[DIM_W-1:0] < r_ctx.nx) && (w_y[DIM_W-1:0] < r_ctx.ny)
                && (w_z[DIM_W-1:0] < r_ctx.nz);
        w_lin = NID_W'(w_z[DIM_W-1:0] * r_ctx.plane)
              + NID_W'(w_y[DIM_W-1:0] * r_ctx.nx) + NID_W'(w_x[DIM_W-1:0]);
        w_lastk = (r_ox == 2'd2) && (r_oy == 2'd2) && (r_oz == 2'd2);

        w_dx = {1'b0, r_px}; w_dy = {1'b0, r_py}; w_dz = {1'b0, r_pz};
        w_ok = 1'b0;
        case (r_ctx.direction)
            DIR_PX: begin w_ok = r_px != r_ctx.nx - 1'b1; w_dx = w_dx + 1'b1; end
            DIR_NX: begin w_ok = r_px != '0; w_dx = w_dx - 1'b1; end
            DIR_PY: begin w_ok = r_py != r_ctx.ny - 1'b1; w_dy = w_dy + 1'b1; end
            DIR_NY: begin w_ok = r_py != '0; w_dy = w_dy - 1'b1; end
            DIR_PZ: begin w_ok = r_pz != r_ctx.nz - 1'b1; w_dz = w_dz + 1'b1; end
            DIR_NZ: begin w_ok = r_pz != '0; w_dz = w_dz - 1'b1; end
            default: w_ok = 1'b0;
        endcase
        w_dlin = NID_W'(w_dz[DIM_W-1:0] * r_ctx.plane)
               + NID_W'(w_dy[DIM_W-1:0] * r_ctx.nx) + NID_W'(w_dx[DIM_W-1:0]);
    end

    // pending in-bound result held back until the next one is found, so is_last can be set on the final one
    logic             r_pend;
    logic [NID_W-1:0] r_pid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_pend <= 1'b0;
            r_fin  <= 1'b0;
        end else if (r_busy && w_oslot) begin
            if (r_ctx.bad || r_ctx.req_type == REQ_FACE) begin
                r_ovld  <= 1'b1;
                r_obad  <= r_ctx.bad;
                r_obd   <= !r_ctx.bad && !w_ok;
                r_oid   <= (!r_ctx.bad && w_ok) ? w_dlin : r_ctx.total;
                r_olast <= 1'b1;
                r_busy  <= 1'b0;
            end else if (r_fin || (w_lastk && !w_inb)) begin
                // final item: the held neighbor, or the cell count when none
                r_ovld  <= 1'b1;
                r_obad  <= 1'b0;
                r_obd   <= 1'b0;
                r_oid   <= r_pend ? r_pid : r_ctx.total;
                r_olast <= 1'b1;
                r_pend  <= 1'b0;
                r_fin   <= 1'b0;
                r_busy  <= 1'b0;
            end else begin
                r_ovld  <= w_inb && r_pend;
                r_obad  <= 1'b0;
                r_obd   <= 1'b0;
                r_oid   <= r_pid;
                r_olast <= 1'b0;
                if (w_inb) begin
                    r_pend <= 1'b1;
                    r_pid  <= w_lin;
                end
                if (w_lastk) begin
                    // flush follows once the output slot is free
                    r_fin <= 1'b1;
                end else if (r_oz == 2'd2) begin
                    r_oz <= 2'd0;
                    if (r_oy == 2'd2) begin
                        r_oy <= 2'd0;
                        r_ox <= r_ox + 2'd1;
                    end else begin
                        r_oy <= r_oy + 2'd1;
                    end
                end else begin
                    r_oz <= r_oz + 2'd1;
                end
            end
        end else begin
            if (o_res.ready) r_ovld <= 1'b0;
            if (!r_busy && w_s2.vld) begin
                r_ctx  <= w_s2.ctx;
                r_pz   <= r_zq[N_CELLS-1];
                r_py   <= DIM_W'(w_s2.quo);
                r_px   <= DIM_W'(w_s2.rem);
                r_ox   <= 2'd0;
                r_oy   <= 2'd0;
                r_oz   <= 2'd0;
                r_pend <= 1'b0;
                r_fin  <= 1'b0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_res.valid            = r_ovld;
    assign o_res.data.neighbor_id = r_oid;
    assign o_res.data.at_border   = r_obd;
    assign o_res.data.bad_index   = r_obad;
    assign o_res.data.is_last     = r_olast;
endmodule

@@ tb/tb_grid_neighbor_index_unit.sv @@
// Testbench for grid_neighbor_index_unit: random and directed cell lookups,
// checked against a local neighbor predictor. Depends on gni_pkg and gni_if.
module tb_grid_neighbor_index_unit import gni_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   DRAIN_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [DIM_W-1:0] i_cfg_data;

    gni_req_if req_ch ();
    gni_res_if res_ch ();

    grid_neighbor_index_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    t_req pending_reqs[$];
    t_res expected_nbrs[$];
    logic [DIM_W-1:0] grid_dim[3];
    int  n_errors = 0;
    bit  sender_pause = 0;
    int  hold_req_cnt = 0;
    int  hold_seen_cnt = 0;
    int  idle_cycles = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic longint eff_size(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic t_res mk_res(longint id, bit border, bit bad, bit last);
        t_res r;
        r.neighbor_id = id[NID_W-1:0];
        r.at_border = border;
        r.bad_index = bad;
        r.is_last = last;
        return r;
    endfunction

    function automatic void add_expected(t_res r);
        expected_nbrs.insert(expected_nbrs.size(), r);
    endfunction

    // queue the neighbor results that one lookup produces
    task automatic predict_neighbors(t_req rq);
        longint nx, ny, nz, plane, total, id, px, py, pz, x, y, z;
        int cnt;
        bit ok;
        t_res r;
        nx = eff_size(grid_dim[0]);
        ny = eff_size(grid_dim[1]);
        nz = eff_size(grid_dim[2]);
        plane = nx * ny;
        total = plane * nz;
        id = rq.cell_id;
        cnt = 0;
        if (id >= total) begin
            add_expected(mk_res(total, 0, 1, 1));
            return;
        end
        pz = id / plane;
        py = (id % plane) / nx;
        px = (id % plane) % nx;
        if (rq.req_type == REQ_ENUM) begin
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++) begin
                        x = px + dx; y = py + dy; z = pz + dz;
                        if (dx == 0 && dy == 0 && dz == 0) continue;
                        if (x < 0 || y < 0 || z < 0 || x >= nx || y >= ny || z >= nz)
                            continue;
                        add_expected(mk_res(z * plane + y * nx + x, 0, 0, 0));
                        cnt++;
                    end
            if (cnt == 0) begin
                add_expected(mk_res(total, 0, 0, 1));
            end else begin
                r = expected_nbrs.pop_back();
                r.is_last = 1'b1;
                add_expected(r);
            end
        end else begin
            x = px; y = py; z = pz;
            case (rq.direction)
                DIR_PX: begin ok = (px != nx - 1); x = px + 1; end
                DIR_NX: begin ok = (px != 0);      x = px - 1; end
                DIR_PY: begin ok = (py != ny - 1); y = py + 1; end
                DIR_NY: begin ok = (py != 0);      y = py - 1; end
                DIR_PZ: begin ok = (pz != nz - 1); z = pz + 1; end
                DIR_NZ: begin ok = (pz != 0);      z = pz - 1; end
                default: ok = 0;
            endcase
            if (ok) add_expected(mk_res(z * plane + y * nx + x, 0, 0, 1));
            else    add_expected(mk_res(total, 1, 0, 1));
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // request driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            nxt_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                predict_neighbors(req_ch.data);
                nxt_valid = 1'b0;
                send_gap = pick_gap();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!sender_pause && pending_reqs.size() > 0) begin
                    req_ch.data <= pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // result monitor and sink stalls
    int sink_stall = 0;
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_nbrs.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, res_ch.data);
                    n_errors++;
                end else begin
                    exp_r = expected_nbrs.pop_front();
                    if (res_ch.data.neighbor_id !== exp_r.neighbor_id ||
                        res_ch.data.at_border !== exp_r.at_border ||
                        res_ch.data.bad_index !== exp_r.bad_index ||
                        res_ch.data.is_last !== exp_r.is_last) begin
                        $display({"%0t: mismatch expected id=%0d border=%b bad=%b last=%b,",
                                  " got id=%0d border=%b bad=%b last=%b"},
                                 $time, exp_r.neighbor_id, exp_r.at_border,
                                 exp_r.bad_index, exp_r.is_last,
                                 res_ch.data.neighbor_id, res_ch.data.at_border,
                                 res_ch.data.bad_index, res_ch.data.is_last);
                        n_errors++;
                    end
                end
            end
            if (hold_seen_cnt != hold_req_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                sink_stall = 1500;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_neighbor_index_unit test failed");
            $finish;
        end
    end

    task automatic write_dim(logic [1:0] idx, logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        grid_dim[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(logic [DIM_W-1:0] sx, logic [DIM_W-1:0] sy,
                            logic [DIM_W-1:0] sz);
        write_dim(REG_SIZE_X, sx);
        write_dim(REG_SIZE_Y, sy);
        write_dim(REG_SIZE_Z, sz);
    endtask

    task automatic queue_req(logic rt, longint id, int dir);
        t_req r;
        r.req_type = rt;
        r.cell_id = id[ID_W-1:0];
        r.direction = dir[DIR_W-1:0];
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // wait until the block has gone quiet
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_nbrs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int n_items);
        longint total;
        int p;
        total = eff_size(grid_dim[0]) * eff_size(grid_dim[1]) * eff_size(grid_dim[2]);
        for (int k = 0; k < n_items; k++) begin
            p = $urandom_range(0, 99);
            if (p < 80)
                queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 32'(total - 1)),
                          int'($urandom_range(0, 7)));
            else if (p < 90)
                queue_req(1'($urandom_range(0, 1)), total - 1 + $urandom_range(0, 2),
                          int'($urandom_range(0, 7)));
            else
                queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 32'h3FFF_FFFF),
                          int'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_SIZE_X;
        i_cfg_data = '0;
        grid_dim[0] = 1; grid_dim[1] = 1; grid_dim[2] = 1;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid is a single cell: no neighbors, everything else out of range
        queue_req(REQ_ENUM, 0, DIR_PX);
        queue_req(REQ_FACE, 0, DIR_NZ);
        queue_req(REQ_FACE, 0, 7);
        queue_req(REQ_ENUM, 1, DIR_PX);
        queue_req(REQ_FACE, 32'h3FFF_FFFF, DIR_PY);
        drain();

        set_grid(4, 3, 2);
        queue_req(REQ_ENUM, 0, 0);
        queue_req(REQ_ENUM, 23, 0);
        queue_req(REQ_ENUM, 17, 0);
        for (int d = 0; d < 8; d++) queue_req(REQ_FACE, 17, d);
        queue_req(REQ_FACE, 0, DIR_NX);
        queue_req(REQ_FACE, 23, DIR_PZ);
        queue_req(REQ_ENUM, 24, 0);
        drain();

        // largest grid: every 30-bit index is valid
        set_grid(MAX_DIM, MAX_DIM, MAX_DIM);
        queue_req(REQ_ENUM, 32'h3FFF_FFFF, 0);
        queue_req(REQ_ENUM, 0, 0);
        queue_req(REQ_FACE, 32'h3FFF_FFFF, DIR_PZ);
        queue_random(30);
        drain();

        // zero acts as one, over-range as the maximum
        set_grid(0, 11'h7FF, 3);
        queue_req(REQ_ENUM, 5000, 0);
        queue_req(REQ_FACE, 3 * 1024, DIR_PY);
        queue_random(20);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                set_grid(DIM_W'($urandom_range(0, 2047)), DIM_W'($urandom_range(0, 2047)),
                         DIM_W'($urandom_range(0, 2047)));
            else
                set_grid(DIM_W'($urandom_range(1, 6)), DIM_W'($urandom_range(1, 6)),
                         DIM_W'($urandom_range(1, 4)));
            if (ph == 1) hold_req_cnt++;
            queue_random(65);
            if (ph == 2) begin
                // hold the sender until every result is back
                while (pending_reqs.size() > 30) @(posedge i_clk);
                sender_pause = 1;
                while (req_ch.valid || expected_nbrs.size() > 0) @(posedge i_clk);
                sender_pause = 0;
            end
            drain();
        end

        if (n_errors == 0)
            $display("grid_neighbor_index_unit test passed");
        else
            $display("grid_neighbor_index_unit test failed");
        $finish;
    end
endmodule
